// ===== design/spf_pkg.sv =====
// Shared types and constants for the stuffed packet framer.
// Used by every module of the framer and by its checker; no dependencies.
package spf_pkg;

  // result kinds shown on the master-side tuser
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_DROP  = 2'd1;
  localparam logic [1:0] KIND_SWAP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_START    = 2'd0;
  localparam logic [1:0] REG_ESCAPE   = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0]  START_RESET    = 8'h7E;
  localparam logic [7:0]  ESCAPE_RESET   = 8'h7D;
  localparam logic [12:0] CAPACITY_RESET = 13'd4096;

  // largest frame that must fit, and physical bank depth
  localparam int MAX_FRAME  = 32;
  localparam int BANK_DEPTH = 4096;

  // raw bytes of a record: 4 stamp, 2 id, up to 8 payload
  localparam int RAW_BYTES = 14;
  localparam int RAW_BITS  = RAW_BYTES * 8;

  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [4:0] PAD_MASK = 5'd7;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [11:0] byte_addr;
    logic        bank_sel;
    logic [12:0] reported_fill;
    logic        last;
  } result_t;

endpackage

// ===== design/spf_shifter.sv =====
// Byte-wide rotating shift register holding the raw record bytes.
// Flags the byte at the head when it equals the start or escape value.
// Depends on spf_pkg.
module spf_shifter (
  input  logic                        clk,
  input  logic                        load,
  input  logic [spf_pkg::RAW_BITS-1:0] load_bytes,
  input  logic                        rotate,
  input  logic [7:0]                  start_value,
  input  logic [7:0]                  escape_value,
  output logic [7:0]                  top_byte,
  output logic                        top_ctrl
);

  localparam int W = spf_pkg::RAW_BITS;

  logic [W-1:0] sr;

  // load a record, or rotate one byte toward the head
  always_ff @(posedge clk) begin
    if (load) begin
      sr <= load_bytes;
    end else if (rotate) begin
      sr <= {sr[W-9:0], sr[W-1:W-8]};
    end
  end

  assign top_byte = sr[W-1:W-8];
  assign top_ctrl = (top_byte == start_value) || (top_byte == escape_value);

endmodule

// ===== design/spf_out_reg.sv =====
// Single-entry output register for the master-side stream.
// Takes a new result whenever it is empty or its result is being taken.
// Depends on spf_pkg.
module spf_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  spf_pkg::result_t din,
  input  logic             ready,
  output logic             valid,
  output spf_pkg::result_t dout,
  output logic             free
);

  assign free = !valid || ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (free && load) begin
      dout <= din;
    end
  end

endmodule

// ===== design/stuffed_packet_framer_pingpong.sv =====
// Byte-stuffing framer for a two-bank log buffer.
// Append: accept, an escape scan over the raw bytes, a space check,
//   then one frame byte per cycle while the output register is free (8 to 32 bytes).
// Drop and swap give one result; a swap is taken in the accept cycle.
// Throughput is set by the byte-serial scan and emit through the shift register.
// Synchronous reset: idle, bank 0, fill 0, registers to 0x7E, 0x7D and 4096.
module stuffed_packet_framer_pingpong (
  input  logic         clk,
  input  logic         rst,
  // slave side
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [119:0] s_tdata,   // stamp[31:0], record_id[47:32], payload[111:48],
                                  // payload_len[115:112], zero fill
  input  logic         s_tuser,   // command
  // master side
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // out_byte[7:0], byte_addr[19:8], bank_sel[20],
                                  // reported_fill[33:21], zero fill
  output logic [1:0]   m_tuser,   // kind
  output logic         m_tlast,   // last
  // configuration
  input  logic         wr_en,
  input  logic [1:0]   wr_index,
  input  logic [12:0]  wr_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_COUNT  = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]  state;
  logic [3:0]  cnt;
  logic [3:0]  esc_cnt;
  logic [3:0]  raw_len;
  logic [4:0]  pad_last;
  logic [4:0]  k;
  logic [3:0]  ri;
  logic        half;
  logic        active_bank;
  logic [12:0] fill_level;
  logic [7:0]  start_value;
  logic [7:0]  escape_value;
  logic [12:0] bank_capacity;

  logic [31:0] in_stamp;
  logic [15:0] in_id;
  logic [63:0] in_payload;
  logic [3:0]  in_len;
  logic [3:0]  len_clamped;
  logic [63:0] pay_top;

  logic [7:0]  top_byte;
  logic        top_ctrl;
  logic        rotate;
  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        out_valid;
  spf_pkg::result_t out_din;
  spf_pkg::result_t out_q;

  logic [4:0]  pad_last_c;
  logic [5:0]  pad_size_c;
  logic [12:0] cap;
  logic [12:0] space;
  logic        drop;
  logic        raw_left;
  logic [12:0] addr_sum;

  assign in_stamp   = s_tdata[31:0];
  assign in_id      = s_tdata[47:32];
  assign in_payload = s_tdata[111:48];
  assign in_len     = s_tdata[115:112];

  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // payload bytes moved so the highest valid index sits at the top
  assign len_clamped = (in_len > 4'd8) ? 4'd8 : in_len;
  assign pay_top     = in_payload << {(4'd8 - len_clamped), 3'b000};

  // frame length and space check
  assign pad_last_c = ({1'b0, raw_len} + {1'b0, esc_cnt}) | spf_pkg::PAD_MASK;
  assign pad_size_c = {1'b0, pad_last_c} + 6'd1;
  assign cap   = (bank_capacity > 13'(spf_pkg::BANK_DEPTH)) ?
                 13'(spf_pkg::BANK_DEPTH) : bank_capacity;
  assign space = (fill_level < cap) ? (cap - fill_level) : 13'd0;
  assign drop  = (space < 13'(spf_pkg::MAX_FRAME)) || (space < {7'd0, pad_size_c});

  assign raw_left = (ri < raw_len);
  assign addr_sum = fill_level + {8'd0, k};

  // shift register advance: every scan cycle, and after each finished data byte
  always_comb begin
    rotate = 1'b0;
    if (state == ST_COUNT) begin
      rotate = 1'b1;
    end else if (state == ST_EMIT && out_free && k != 5'd0 && raw_left) begin
      rotate = half || !top_ctrl;
    end
  end

  // result selection
  always_comb begin
    out_load = 1'b0;
    out_din  = '0;
    out_din.bank_sel = active_bank;
    out_din.last     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser) begin
          out_load = 1'b1;
          out_din.kind = spf_pkg::KIND_SWAP;
          out_din.reported_fill = fill_level;
        end
      end
      ST_DECIDE: begin
        if (drop) begin
          out_load = 1'b1;
          out_din.kind = spf_pkg::KIND_DROP;
        end
      end
      ST_EMIT: begin
        out_load = 1'b1;
        out_din.kind = spf_pkg::KIND_FRAME;
        out_din.byte_addr = addr_sum[11:0];
        out_din.last = (k == pad_last);
        if (k == 5'd0) begin
          out_din.out_byte = start_value;
        end else if (raw_left) begin
          if (half) begin
            out_din.out_byte = top_byte ^ spf_pkg::ESC_XOR;
          end else if (top_ctrl) begin
            out_din.out_byte = escape_value;
          end else begin
            out_din.out_byte = top_byte;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value   <= spf_pkg::START_RESET;
      escape_value  <= spf_pkg::ESCAPE_RESET;
      bank_capacity <= spf_pkg::CAPACITY_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        spf_pkg::REG_START:    start_value   <= wr_data[7:0];
        spf_pkg::REG_ESCAPE:   escape_value  <= wr_data[7:0];
        spf_pkg::REG_CAPACITY: bank_capacity <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and bank state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active_bank <= 1'b0;
      fill_level  <= 13'd0;
      cnt         <= 4'd0;
      esc_cnt     <= 4'd0;
      raw_len     <= 4'd0;
      pad_last    <= 5'd0;
      k           <= 5'd0;
      ri          <= 4'd0;
      half        <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              fill_level  <= 13'd0;
              active_bank <= ~active_bank;
            end else begin
              state   <= ST_COUNT;
              cnt     <= 4'd0;
              esc_cnt <= 4'd0;
              raw_len <= 4'd6 + len_clamped;
            end
          end
        end
        ST_COUNT: begin
          if (cnt < raw_len && top_ctrl) begin
            esc_cnt <= esc_cnt + 4'd1;
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'(spf_pkg::RAW_BYTES - 1)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          pad_last <= pad_last_c;
          k        <= 5'd0;
          ri       <= 4'd0;
          half     <= 1'b0;
          if (!drop) begin
            state <= ST_EMIT;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            k <= k + 5'd1;
            if (k != 5'd0 && raw_left) begin
              if (half) begin
                half <= 1'b0;
                ri   <= ri + 4'd1;
              end else if (top_ctrl) begin
                half <= 1'b1;
              end else begin
                ri <= ri + 4'd1;
              end
            end
            if (k == pad_last) begin
              fill_level <= fill_level + {8'd0, pad_last} + 13'd1;
              state      <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  spf_shifter u_shifter (
    .clk          (clk),
    .load         (accept && !s_tuser),
    .load_bytes   ({in_stamp, in_id, pay_top}),
    .rotate       (rotate),
    .start_value  (start_value),
    .escape_value (escape_value),
    .top_byte     (top_byte),
    .top_ctrl     (top_ctrl)
  );

  spf_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (out_load),
    .din   (out_din),
    .ready (m_tready),
    .valid (out_valid),
    .dout  (out_q),
    .free  (out_free)
  );

  assign m_tvalid = out_valid;
  assign m_tuser  = out_q.kind;
  assign m_tlast  = out_q.last;
  assign m_tdata  = {6'd0, out_q.reported_fill, out_q.bank_sel, out_q.byte_addr,
                     out_q.out_byte};

endmodule

// ===== design/spf_checker.sv =====
// Port-level checks for the stuffed packet framer, bound to its top level.
// Depends on spf_pkg and stuffed_packet_framer_pingpong.
module spf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [39:0]  m_tdata,
  input logic [1:0]   m_tuser,
  input logic         m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled result changed");

  // a new request is taken only when the output can take its result
  a_in_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("request accepted while output blocked");

  // frames are padded so the last byte ends an 8-byte block
  a_pad_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == spf_pkg::KIND_FRAME && m_tlast) |-> (m_tdata[10:8] == 3'd7))
    else $error("frame does not end on an 8-byte boundary");

  // drop and swap reports are single results
  a_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != spf_pkg::KIND_FRAME) |-> m_tlast)
    else $error("report without last");

endmodule

bind stuffed_packet_framer_pingpong spf_checker u_spf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
